@@ hdl/acsp_pkg.sv @@
package acsp_pkg;

  // Result status codes
  localparam logic [1:0] ST_NO_OK   = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NO_CALL = 2'd2;
  localparam logic [1:0] ST_PARSED  = 2'd3;

  // Characters of the call line prefix
  localparam int unsigned PREFIX_LEN = 9;
  localparam int unsigned IDX_W      = $clog2(PREFIX_LEN + 1);

  // Result of one character step, parser to top level
  typedef struct packed {
    logic       fire;
    logic [1:0] status;
    logic       active;
  } acsp_res_t;

  function automatic logic [7:0] prefix_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "+";
      4'd1:    c = "M";
      4'd2:    c = "I";
      4'd3:    c = "P";
      4'd4:    c = "C";
      4'd5:    c = "A";
      4'd6:    c = "L";
      4'd7:    c = "L";
      4'd8:    c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/acsp_parse.sv @@
module acsp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  output acsp_pkg::acsp_res_t res
);
  import acsp_pkg::*;

  // Line parser phases
  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_O        = 4'd1;
  localparam logic [3:0] PH_OK       = 4'd2;
  localparam logic [3:0] PH_PREFIX   = 4'd3;
  localparam logic [3:0] PH_CID_PRE  = 4'd4;
  localparam logic [3:0] PH_CID      = 4'd5;
  localparam logic [3:0] PH_CID_POST = 4'd6;
  localparam logic [3:0] PH_ST_PRE   = 4'd7;
  localparam logic [3:0] PH_ST       = 4'd8;
  localparam logic [3:0] PH_ST_POST  = 4'd9;
  localparam logic [3:0] PH_SKIP     = 4'd10;

  // Call line outcome codes
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_BAD  = 2'd1;
  localparam logic [1:0] OUT_GOOD = 2'd2;

  logic [3:0]       parse_phase, parse_phase_next;
  logic [IDX_W-1:0] match_index, match_index_next;
  logic             ok_line_seen, ok_line_seen_next;
  logic [1:0]       call_outcome, call_outcome_next;
  logic [1:0]       call_state_clamped, call_state_clamped_next;
  logic             call_active_flag, call_active_flag_next;

  logic       blank, digit, eol, eor;
  logic [7:0] dval;
  logic [1:0] dsat;

  assign blank = (ch == 8'h20) || (ch == 8'h09);
  assign digit = (ch >= "0") && (ch <= "9");
  assign eol   = (ch == 8'h0d) || (ch == 8'h0a);
  assign eor   = (ch == 8'h00);
  assign dval  = ch - "0";
  assign dsat  = (dval > 8'd2) ? 2'd2 : dval[1:0];

  // Next state for one character
  always_comb begin
    logic fin, bad;
    parse_phase_next        = parse_phase;
    match_index_next        = match_index;
    ok_line_seen_next       = ok_line_seen;
    call_outcome_next       = call_outcome;
    call_state_clamped_next = call_state_clamped;
    call_active_flag_next   = call_active_flag;
    fin = 1'b0;
    bad = 1'b0;

    if (eol || eor) begin
      // line end: settle the line that was open
      case (parse_phase)
        PH_OK: ok_line_seen_next = 1'b1;
        PH_CID_PRE, PH_CID, PH_CID_POST, PH_ST_PRE: bad = 1'b1;
        PH_ST, PH_ST_POST: fin = 1'b1;
        default: ;
      endcase
    end else begin
      case (parse_phase)
        PH_START: begin
          if (!blank) begin
            if (ch == "O") begin
              parse_phase_next = PH_O;
            end else if (ch == "+" && call_outcome == OUT_NONE) begin
              parse_phase_next = PH_PREFIX;
              match_index_next = IDX_W'(1);
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
        end
        PH_O: parse_phase_next = (ch == "K") ? PH_OK : PH_SKIP;
        PH_OK: if (!blank) parse_phase_next = PH_SKIP;
        PH_PREFIX: begin
          if (match_index < IDX_W'(PREFIX_LEN) && ch == prefix_char(match_index)) begin
            match_index_next = match_index + IDX_W'(1);
            if (match_index_next == IDX_W'(PREFIX_LEN)) parse_phase_next = PH_CID_PRE;
          end else begin
            parse_phase_next = PH_SKIP;
          end
        end
        PH_CID_PRE: begin
          if (!blank) begin
            if (digit) parse_phase_next = PH_CID;
            else bad = 1'b1;
          end
        end
        PH_CID: begin
          if (!digit) begin
            if (blank) parse_phase_next = PH_CID_POST;
            else if (ch == ",") parse_phase_next = PH_ST_PRE;
            else bad = 1'b1;
          end
        end
        PH_CID_POST: begin
          if (!blank) begin
            if (ch == ",") parse_phase_next = PH_ST_PRE;
            else bad = 1'b1;
          end
        end
        PH_ST_PRE: begin
          if (!blank) begin
            if (digit) begin
              call_state_clamped_next = dsat;
              parse_phase_next        = PH_ST;
            end else begin
              bad = 1'b1;
            end
          end
        end
        PH_ST: begin
          if (digit) begin
            // saturate: a second digit after a non-zero one means > 1
            call_state_clamped_next = (call_state_clamped >= 2'd1) ? 2'd2 : dsat;
          end else if (blank) begin
            parse_phase_next = PH_ST_POST;
          end else if (ch == ",") begin
            fin = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        PH_ST_POST: begin
          if (!blank) begin
            if (ch == ",") fin = 1'b1;
            else bad = 1'b1;
          end
        end
        default: parse_phase_next = PH_SKIP;
      endcase
    end

    // close the call line
    if (bad) begin
      call_outcome_next = OUT_BAD;
      parse_phase_next  = PH_SKIP;
    end else if (fin) begin
      if (call_state_clamped_next > 2'd1) begin
        call_outcome_next = OUT_BAD;
      end else begin
        call_outcome_next     = OUT_GOOD;
        call_active_flag_next = (call_state_clamped_next == 2'd1);
      end
      parse_phase_next = PH_SKIP;
    end

    if (eol || eor) begin
      parse_phase_next = PH_START;
      match_index_next = '0;
    end
  end

  // Result for a terminating character
  always_comb begin
    res.fire   = step && eor;
    res.active = 1'b0;
    if (!ok_line_seen_next) begin
      res.status = ST_NO_OK;
    end else if (call_outcome_next == OUT_BAD) begin
      res.status = ST_BAD;
    end else if (call_outcome_next == OUT_NONE) begin
      res.status = ST_NO_CALL;
    end else begin
      res.status = ST_PARSED;
      res.active = call_active_flag_next;
    end
  end

  // State registers; a terminating character starts a fresh response
  always_ff @(posedge clk) begin
    if (rst || (step && eor)) begin
      parse_phase        <= PH_START;
      match_index        <= '0;
      ok_line_seen       <= 1'b0;
      call_outcome       <= OUT_NONE;
      call_state_clamped <= 2'd0;
      call_active_flag   <= 1'b0;
    end else if (step) begin
      parse_phase        <= parse_phase_next;
      match_index        <= match_index_next;
      ok_line_seen       <= ok_line_seen_next;
      call_outcome       <= call_outcome_next;
      call_state_clamped <= call_state_clamped_next;
      call_active_flag   <= call_active_flag_next;
    end
  end

endmodule

@@ hdl/at_call_status_parser.sv @@
// Call status parser for modem text responses.
//
// Input channel (ch_valid / ch_ready / ch) carries one response character
// per request. CR and LF end a line; a zero character ends the response
// and is the only character that produces a result.
// Output channel (res_valid / res_ready / status / active) carries one
// result per response: status 0 no OK line, 1 malformed call line,
// 2 no call line, 3 parsed; active is 1 only for status 3 with state 1.
//
// Throughput: one character per cycle, save where a zero character waits as
// described below. A character sits in the input register and is parsed on
// its way into the result register, which shows the result of a zero character.
// The per-character parser state update is the only loop.
// When the receiver stalls, the result register holds; the input register
// still takes characters that yield no result, and only a second zero
// character waits until the pending result is taken.
// Reset (rst, synchronous) empties both registers and returns the parser
// to the start of a fresh response.
module at_call_status_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       ch_valid,
  output logic       ch_ready,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] status,
  output logic       active
);
  import acsp_pkg::*;

  logic       ch_held;
  logic [7:0] ch_reg;
  logic       advance;
  logic       eor_held;
  acsp_res_t  res;

  // A held character moves on unless it yields a result with nowhere to go
  assign eor_held = (ch_reg == 8'h00);
  assign advance  = ch_held && (!eor_held || !res_valid || res_ready);
  assign ch_ready = !ch_held || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_held <= 1'b0;
    end else if (ch_ready) begin
      ch_held <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready && ch_valid) ch_reg <= ch;
  end

  acsp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (ch_reg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res.fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      status <= res.status;
      active <= res.active;
    end
  end

endmodule

@@ hdl/acsp_checker.sv @@
module acsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       ch_valid,
  input logic       ch_ready,
  input logic [7:0] ch,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] status,
  input logic       active
);
  import acsp_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(active))
    else $error("result changed while stalled");

  // Active only for a parsed call line
  a_active: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_PARSED |-> !active)
    else $error("active set without parsed status");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // With no result pending the input is always open
  a_open: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> ch_ready)
    else $error("input stalled with empty output");

  // A non-terminating character alone never raises a result
  a_nores: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !(ch_valid && ch_ready && ch == 8'h00) ##1 !res_valid |=> !res_valid)
    else $error("result without terminating character");

endmodule

bind at_call_status_parser acsp_checker u_chk (.*);
